// ----- rtl/stma_pkg.sv -----
// ============================================================================
// stma_pkg: shared types and constants of the sparse triplet merge-add block
// Field widths, function codes, list entry and result layouts, and the
// saturating adder used by the merge step.
// ============================================================================
package stma_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned ROW_W  = 16;
  localparam int unsigned COL_W  = 16;
  localparam int unsigned VAL_W  = 32;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Input function codes; the fourth code is unused and ignored.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_MERGE  = 2'd2
  } func_e;

  // Merge sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP,
    ST_FLUSH
  } state_e;

  // One stored triplet.
  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] val;
  } entry_t;

  // One result transaction.
  typedef struct packed {
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
    logic                    empty_res;
  } result_t;

  // True when a sorts ahead of b: row first, then column.
  function automatic logic entry_before(entry_t a, entry_t b);
    if (a.row != b.row) begin
      return a.row < b.row;
    end
    return a.col < b.col;
  endfunction

  // Signed add clamped to the value range.
  function automatic logic signed [VAL_W-1:0] sat_add(logic signed [VAL_W-1:0] a,
                                                      logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      return s[VAL_W] ? VAL_MIN : VAL_MAX;
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

// ----- rtl/stma_if.sv -----
// ============================================================================
// stma_if: valid/ready channels of the sparse triplet merge-add block
// The command channel carries loads and merge starts; the result channel
// carries the merged triplets.
// ============================================================================
interface stma_in_if import stma_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [ROW_W-1:0]        row_index;
  logic [COL_W-1:0]        col_index;
  logic signed [VAL_W-1:0] entry_value;

  modport source (output valid, output func, output row_index, output col_index,
                  output entry_value, input ready);
  modport sink   (input valid, input func, input row_index, input col_index,
                  input entry_value, output ready);
endinterface

interface stma_out_if import stma_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_col;
  logic signed [VAL_W-1:0] out_value;
  logic                    last;
  logic                    empty_res;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output last, output empty_res, input ready);
  modport sink   (input valid, input out_row, input out_col, input out_value,
                  input last, input empty_res, output ready);
endinterface

// ----- rtl/stma_ram.sv -----
// ============================================================================
// stma_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module stma_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sparse_triplet_merge_add_core.sv -----
// ============================================================================
// sparse_triplet_merge_add_core: sparse matrix addition over triplet lists
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    func, row_index, col_index, entry_value
//   out_o    out  valid/ready    out_row, out_col, out_value, last, empty_res
//
// Loads can follow back to back. Each merge comparison step reads the list
// RAMs (ST_READ), then compares and adds (ST_STEP), for at most na + nb
// steps, plus a closing read that finds both lists done and a flush that
// emits the final result; the registered RAM read sets the read state.
// A stalled result channel holds the merge.
// Reset clears both counts and the sequencer; list RAM contents are not reset.
// ============================================================================
module sparse_triplet_merge_add_core
  import stma_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stma_in_if.sink    in_i,
  stma_out_if.source out_o
);

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0] idx_a_q, idx_a_d, idx_b_q, idx_b_d;
  entry_t        pend_q, pend_d;
  logic          pend_v_q, pend_v_d;
  result_t       out_q, out_d;
  logic          out_v_q, out_v_d;

  logic          in_acc, we_a, we_b, rd_en;
  entry_t        in_entry, head_a, head_b, cand;
  logic [63:0]   rdata_a, rdata_b;
  logic          a_has, b_has, same_pos, a_first, produce, out_free;
  logic signed [VAL_W-1:0] sum_val;

  assign in_entry = '{row: in_i.row_index, col: in_i.col_index, val: in_i.entry_value};
  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign rd_en    = (state_q == ST_READ);

  // List storage, one RAM per list.
  stma_ram #(.WIDTH($bits(entry_t)), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[IW-1:0]),
    .wdata_i (in_entry),
    .re_i    (rd_en),
    .raddr_i (idx_a_q[IW-1:0]),
    .rdata_o (rdata_a)
  );

  stma_ram #(.WIDTH($bits(entry_t)), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[IW-1:0]),
    .wdata_i (in_entry),
    .re_i    (rd_en),
    .raddr_i (idx_b_q[IW-1:0]),
    .rdata_o (rdata_b)
  );

  assign head_a = entry_t'(rdata_a);
  assign head_b = entry_t'(rdata_b);

  // Shared compare and saturating add unit for the current heads.
  assign a_has    = idx_a_q < cnt_a_q;
  assign b_has    = idx_b_q < cnt_b_q;
  assign same_pos = a_has && b_has && (head_a.row == head_b.row) &&
                    (head_a.col == head_b.col);
  assign a_first  = a_has && (!b_has || entry_before(head_a, head_b));
  assign sum_val  = sat_add(head_a.val, head_b.val);

  always_comb begin
    if (same_pos) begin
      cand    = '{row: head_a.row, col: head_a.col, val: sum_val};
      produce = (sum_val != '0);
    end else if (a_first) begin
      cand    = head_a;
      produce = 1'b1;
    end else begin
      cand    = head_b;
      produce = 1'b1;
    end
  end

  assign out_free = !out_v_q || out_o.ready;

  // Sequencer: loads, merge steps and the final flush.
  always_comb begin
    state_d  = state_q;
    cnt_a_d  = cnt_a_q;
    cnt_b_d  = cnt_b_q;
    idx_a_d  = idx_a_q;
    idx_b_d  = idx_b_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q && !out_o.ready;
    we_a     = 1'b0;
    we_b     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.func)
            FUNC_LOAD_A: begin
              if (cnt_a_q < DEPTH_C) begin
                we_a    = 1'b1;
                cnt_a_d = cnt_a_q + CW'(1);
              end
            end
            FUNC_LOAD_B: begin
              if (cnt_b_q < DEPTH_C) begin
                we_b    = 1'b1;
                cnt_b_d = cnt_b_q + CW'(1);
              end
            end
            FUNC_MERGE: begin
              idx_a_d = '0;
              idx_b_d = '0;
              state_d = ST_READ;
            end
            default: ;
          endcase
        end
      end

      ST_READ: begin
        state_d = (a_has || b_has) ? ST_STEP : ST_FLUSH;
      end

      ST_STEP: begin
        // A new result pushes the held one out, so it waits on a full output.
        if (!(produce && pend_v_q && !out_free)) begin
          if (produce) begin
            if (pend_v_q) begin
              out_d   = '{out_row: pend_q.row, out_col: pend_q.col,
                          out_value: pend_q.val, last: 1'b0, empty_res: 1'b0};
              out_v_d = 1'b1;
            end
            pend_d   = cand;
            pend_v_d = 1'b1;
          end
          if (same_pos || a_first) begin
            idx_a_d = idx_a_q + CW'(1);
          end
          if (same_pos || !a_first) begin
            idx_b_d = idx_b_q + CW'(1);
          end
          state_d = ST_READ;
        end
      end

      ST_FLUSH: begin
        // The held result is the last one; with none held the sum is empty.
        if (out_free) begin
          if (pend_v_q) begin
            out_d = '{out_row: pend_q.row, out_col: pend_q.col,
                      out_value: pend_q.val, last: 1'b1, empty_res: 1'b0};
          end else begin
            out_d = '{out_row: '0, out_col: '0, out_value: '0,
                      last: 1'b1, empty_res: 1'b1};
          end
          out_v_d  = 1'b1;
          pend_v_d = 1'b0;
          cnt_a_d  = '0;
          cnt_b_d  = '0;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_a_q  <= '0;
      cnt_b_q  <= '0;
      idx_a_q  <= '0;
      idx_b_q  <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_a_q  <= cnt_a_d;
      cnt_b_q  <= cnt_b_d;
      idx_a_q  <= idx_a_d;
      idx_b_q  <= idx_b_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // Result channel.
  assign out_o.valid     = out_v_q;
  assign out_o.out_row   = out_q.out_row;
  assign out_o.out_col   = out_q.out_col;
  assign out_o.out_value = out_q.out_value;
  assign out_o.last      = out_q.last;
  assign out_o.empty_res = out_q.empty_res;

`ifndef NO_ASSERTIONS
  // Merge cursors never run past the list fills.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (idx_a_q <= cnt_a_q && idx_b_q <= cnt_b_q &&
                              cnt_a_q <= DEPTH_C && cnt_b_q <= DEPTH_C))
    else $error("merge cursor beyond list fill");

  // No result is held back once the sequencer is idle.
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("held result left over after merge");

  // Finishing a merge empties both lists and emits a closing result.
  a_flush_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && out_free) |=>
      (cnt_a_q == '0 && cnt_b_q == '0 && out_v_q && out_q.last))
    else $error("merge end did not clear lists or close the result stream");

  // An empty-sum result is always the last one.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.empty_res) |-> out_q.last)
    else $error("empty result without last");
`endif

endmodule

// ----- tb/tb_sparse_triplet_merge_add_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_sparse_triplet_merge_add_core: self-checking bench of the triplet merge
// A short table of loads and merges, some with their result typed in, is
// followed by random phases of sorted triplet lists, some broken or overfull.
// Every result is checked against its typed value or a behavioral model of
// the two lists, with random gaps and stalls on both channels.
// ============================================================================
module tb_sparse_triplet_merge_add_core;
  import stma_pkg::*;

  localparam int unsigned LIST_DEPTH  = 32;
  localparam int unsigned TARGET_CMDS = 460;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned END_HOLD    = 150;
  localparam int unsigned NUM_DIR     = 26;

  // The fourth function code is unused; the block ignores it.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam result_t EMPTY_SUM = '{16'd0, 16'd0, 32'sd0, 1'b1, 1'b1};
  localparam result_t NO_RES    = '0;

  // One row of the directed table; res is used only where typed is set.
  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] val;
    logic                    typed;
    result_t                 res;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    // Merge right after reset: both lists are empty.
    '{FUNC_MERGE,  16'h0000, 16'h0000, 32'sd0,   1'b1, EMPTY_SUM},
    // Largest coordinates, sum saturates high.
    '{FUNC_LOAD_A, 16'hFFFF, 16'hFFFF, VAL_MAX,  1'b0, NO_RES},
    '{FUNC_LOAD_B, 16'hFFFF, 16'hFFFF, 32'sd1,   1'b0, NO_RES},
    '{FUNC_MERGE,  16'h0000, 16'h0000, 32'sd0,   1'b1,
      '{16'hFFFF, 16'hFFFF, VAL_MAX, 1'b1, 1'b0}},
    // Smallest coordinates, sum saturates low.
    '{FUNC_LOAD_A, 16'h0000, 16'h0000, VAL_MIN,  1'b0, NO_RES},
    '{FUNC_LOAD_B, 16'h0000, 16'h0000, -32'sd1,  1'b0, NO_RES},
    '{FUNC_MERGE,  16'h0000, 16'h0000, 32'sd0,   1'b1,
      '{16'h0000, 16'h0000, VAL_MIN, 1'b1, 1'b0}},
    // Sum of zero is dropped, leaving an empty result.
    '{FUNC_LOAD_A, 16'h0005, 16'h0005, 32'sd1234,  1'b0, NO_RES},
    '{FUNC_LOAD_B, 16'h0005, 16'h0005, -32'sd1234, 1'b0, NO_RES},
    '{FUNC_MERGE,  16'h0000, 16'h0000, 32'sd0,     1'b1, EMPTY_SUM},
    // The unused code must not load anything.
    '{FUNC_UNUSED, 16'hFFFF, 16'hFFFF, -32'sd1,  1'b0, NO_RES},
    '{FUNC_MERGE,  16'h0000, 16'h0000, 32'sd0,   1'b1, EMPTY_SUM},
    // Mixed pass-through, sum, dropped sum, with noise in between.
    '{FUNC_LOAD_A, 16'h0001, 16'h0002, 32'sd5,   1'b0, NO_RES},
    '{FUNC_LOAD_A, 16'h0003, 16'h0000, -32'sd7,  1'b0, NO_RES},
    '{FUNC_LOAD_B, 16'h0001, 16'h0002, 32'sd6,   1'b0, NO_RES},
    '{FUNC_LOAD_B, 16'h0002, 16'h0009, VAL_MAX,  1'b0, NO_RES},
    '{FUNC_LOAD_B, 16'h0003, 16'h0000, 32'sd7,   1'b0, NO_RES},
    '{FUNC_UNUSED, 16'h0000, 16'h0000, 32'sd0,   1'b0, NO_RES},
    '{FUNC_MERGE,  16'h0000, 16'h0000, 32'sd0,   1'b0, NO_RES},
    // Unsorted lists still merge step by step.
    '{FUNC_LOAD_A, 16'h0009, 16'h0009, 32'sd1,   1'b0, NO_RES},
    '{FUNC_LOAD_A, 16'h0002, 16'h0002, 32'sd2,   1'b0, NO_RES},
    '{FUNC_LOAD_B, 16'h0005, 16'h0005, 32'sd3,   1'b0, NO_RES},
    '{FUNC_LOAD_B, 16'h0001, 16'h0001, 32'sd4,   1'b0, NO_RES},
    '{FUNC_MERGE,  16'h0000, 16'h0000, 32'sd0,   1'b0, NO_RES},
    // Only list B holds an entry.
    '{FUNC_LOAD_B, 16'h1234, 16'hABCD, -32'sd5,  1'b0, NO_RES},
    '{FUNC_MERGE,  16'h0000, 16'h0000, 32'sd0,   1'b1,
      '{16'h1234, 16'hABCD, -32'sd5, 1'b1, 1'b0}}
  };

  logic clk_i;
  logic rst_ni = 1'b0;

  stma_in_if  cmd_if ();
  stma_out_if res_if ();

  sparse_triplet_merge_add_core #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  // Model state: the two lists and their fill counts.
  entry_t      lst_a [LIST_DEPTH];
  entry_t      lst_b [LIST_DEPTH];
  int unsigned cnt_a = 0;
  int unsigned cnt_b = 0;

  result_t     expected_sums [$];
  result_t     typed_res;
  bit          typed_pending = 1'b0;
  bit          burst = 1'b0;
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // Applies one command to the list model and queues the sums a merge gives.
  function automatic void apply_triplet_cmd(input logic [FUNC_W-1:0] code, input entry_t e);
    int unsigned ia, ib;
    longint      total;
    entry_t      ea, eb, pick;
    bit          same, take_a, emit, have_held;
    result_t     held;
    case (code)
      FUNC_LOAD_A: begin
        if (cnt_a < LIST_DEPTH) begin
          lst_a[cnt_a] = e;
          cnt_a++;
        end
      end
      FUNC_LOAD_B: begin
        if (cnt_b < LIST_DEPTH) begin
          lst_b[cnt_b] = e;
          cnt_b++;
        end
      end
      FUNC_MERGE: begin
        ia = 0;
        ib = 0;
        have_held = 1'b0;
        held = NO_RES;
        while (ia < cnt_a || ib < cnt_b) begin
          if (ia < cnt_a) ea = lst_a[ia];
          if (ib < cnt_b) eb = lst_b[ib];
          same = ia < cnt_a && ib < cnt_b && ea.row == eb.row && ea.col == eb.col;
          take_a = ia < cnt_a &&
                   (ib >= cnt_b || ea.row < eb.row || (ea.row == eb.row && ea.col < eb.col));
          emit = 1'b1;
          if (same) begin
            total = longint'($signed(ea.val)) + longint'($signed(eb.val));
            if (total > longint'(VAL_MAX)) total = longint'(VAL_MAX);
            if (total < longint'(VAL_MIN)) total = longint'(VAL_MIN);
            pick = '{row: ea.row, col: ea.col, val: total[VAL_W-1:0]};
            emit = (total != 0);
            ia++;
            ib++;
          end else if (take_a) begin
            pick = ea;
            ia++;
          end else begin
            pick = eb;
            ib++;
          end
          // Hold each result back one step so the final one can be marked.
          if (emit) begin
            if (have_held) expected_sums.push_back(held);
            held = '{pick.row, pick.col, pick.val, 1'b0, 1'b0};
            have_held = 1'b1;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
        end else begin
          held = EMPTY_SUM;
        end
        expected_sums.push_back(held);
        cnt_a = 0;
        cnt_b = 0;
      end
      default: ;
    endcase
  endfunction

  // Scoreboard: check each result transaction, then model each command.
  always @(posedge clk_i) begin : scoreboard
    int unsigned depth0;
    result_t     want;
    entry_t      e;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (expected_sums.size() == 0) begin
          report_mismatch("unexpected result row", res_if.out_row, -1);
        end else begin
          want = expected_sums.pop_front();
          if (res_if.out_row !== want.out_row)
            report_mismatch("out_row", res_if.out_row, want.out_row);
          if (res_if.out_col !== want.out_col)
            report_mismatch("out_col", res_if.out_col, want.out_col);
          if (res_if.out_value !== want.out_value)
            report_mismatch("out_value", res_if.out_value, want.out_value);
          if (res_if.last !== want.last)
            report_mismatch("last", res_if.last, want.last);
          if (res_if.empty_res !== want.empty_res)
            report_mismatch("empty_res", res_if.empty_res, want.empty_res);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        e = '{row: cmd_if.row_index, col: cmd_if.col_index, val: cmd_if.entry_value};
        depth0 = expected_sums.size();
        apply_triplet_cmd(cmd_if.func, e);
        // A typed row replaces what the model queued for this merge.
        if (typed_pending && cmd_if.func == FUNC_MERGE) begin
          while (expected_sums.size() > depth0) void'(expected_sums.pop_back());
          expected_sums.push_back(typed_res);
          typed_pending = 1'b0;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** sparse_triplet_merge_add_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall before each transaction unless in a burst.
  initial begin : result_sink
    int unsigned stall;
    res_if.ready = 1'b0;
    forever begin
      stall = burst ? 0 : $urandom_range(0, 6);
      @(negedge clk_i);
      if (stall != 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (!(rst_ni && res_if.valid && res_if.ready));
    end
  end

  // Sends one command; starts and returns at a falling edge with valid left high.
  task automatic send_cmd(input logic [FUNC_W-1:0] code, input entry_t e);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      cmd_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid       = 1'b1;
    cmd_if.func        = code;
    cmd_if.row_index   = e.row;
    cmd_if.col_index   = e.col;
    cmd_if.entry_value = e.val;
    do @(posedge clk_i); while (!(cmd_if.valid && cmd_if.ready));
    @(negedge clk_i);
  endtask

  function automatic logic signed [VAL_W-1:0] draw_value();
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return 32'($urandom_range(0, 16)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  // One random phase: build sorted coordinates, split them over the two lists,
  // load them interleaved with noise, then merge. Returns the commands that count.
  task automatic run_phase(output int unsigned counted);
    entry_t      qa [$];
    entry_t      qb [$];
    entry_t      e, tmp;
    int          r, c;
    int unsigned n, u, kind, where, x, y, fill_a, fill_b;
    logic signed [VAL_W-1:0] va;
    kind = $urandom_range(0, 9);
    case (kind)
      0:       n = 0;
      1:       n = $urandom_range(33, 38);
      2:       n = $urandom_range(9, 20);
      default: n = $urandom_range(1, 7);
    endcase
    r = ($urandom_range(0, 3) == 0) ? 65535 - $urandom_range(0, 3) : $urandom_range(0, 65535);
    c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
    for (u = 0; u < n; u++) begin
      if (u != 0) begin
        if ($urandom_range(0, 2) == 0) begin
          r += $urandom_range(1, 3);
          c = $urandom_range(0, 65535);
        end else begin
          c += $urandom_range(1, 4);
        end
        if (c > 65535) begin
          r += 1;
          c = $urandom_range(0, 3);
        end
        if (r > 65535) break;
      end
      va = draw_value();
      e = '{row: r[ROW_W-1:0], col: c[COL_W-1:0], val: va};
      // An overfull phase puts every coordinate in both lists.
      where = (kind == 1) ? 2 : $urandom_range(0, 3);
      if (where != 1) qa.push_back(e);
      if (where != 0) begin
        if (where == 3 || kind == 1) begin
          e.val = draw_value();
        end else if ($urandom_range(0, 3) == 0) begin
          e.val = -va;
        end
        qb.push_back(e);
      end
    end
    // Now and then the lists come out of order.
    if ($urandom_range(0, 5) == 0 && qa.size() > 1) begin
      repeat (3) begin
        x = $urandom_range(0, qa.size() - 1);
        y = $urandom_range(0, qa.size() - 1);
        tmp = qa[x];
        qa[x] = qa[y];
        qa[y] = tmp;
      end
    end
    if ($urandom_range(0, 5) == 0 && qb.size() > 1) begin
      repeat (3) begin
        x = $urandom_range(0, qb.size() - 1);
        y = $urandom_range(0, qb.size() - 1);
        tmp = qb[x];
        qb[x] = qb[y];
        qb[y] = tmp;
      end
    end
    counted = 0;
    fill_a = 0;
    fill_b = 0;
    while (qa.size() != 0 || qb.size() != 0) begin
      if ($urandom_range(0, 15) == 0) begin
        e = '{row: ROW_W'($urandom), col: COL_W'($urandom), val: $urandom};
        send_cmd(FUNC_UNUSED, e);
      end
      if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1) == 0)) begin
        send_cmd(FUNC_LOAD_A, qa.pop_front());
        if (fill_a < LIST_DEPTH) counted++;
        fill_a++;
      end else begin
        send_cmd(FUNC_LOAD_B, qb.pop_front());
        if (fill_b < LIST_DEPTH) counted++;
        fill_b++;
      end
    end
    e = '{row: ROW_W'($urandom), col: COL_W'($urandom), val: $urandom};
    send_cmd(FUNC_MERGE, e);
    counted++;
  endtask

  initial begin : stimulus
    int unsigned cmds, got, phase, k;
    entry_t      e;
    cmd_if.valid       = 1'b0;
    cmd_if.func        = FUNC_LOAD_A;
    cmd_if.row_index   = '0;
    cmd_if.col_index   = '0;
    cmd_if.entry_value = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table.
    for (k = 0; k < NUM_DIR; k++) begin
      if (DIR_ROWS[k].typed) begin
        typed_res     = DIR_ROWS[k].res;
        typed_pending = 1'b1;
      end
      e = '{row: DIR_ROWS[k].row, col: DIR_ROWS[k].col, val: DIR_ROWS[k].val};
      send_cmd(DIR_ROWS[k].func, e);
    end

    // Random phases, some in bursts without gaps or stalls.
    cmds = 0;
    phase = 0;
    while (cmds < TARGET_CMDS) begin
      burst = ($urandom_range(0, 3) == 0);
      run_phase(got);
      cmds += got;
      // Every fifth phase, hold the command side until the merge has drained completely.
      if (phase % 5 == 2) begin
        cmd_if.valid = 1'b0;
        while (expected_sums.size() != 0) @(negedge clk_i);
      end
      phase++;
    end

    cmd_if.valid = 1'b0;
    burst = 1'b0;
    while (expected_sums.size() != 0) @(negedge clk_i);
    repeat (END_HOLD) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("** sparse_triplet_merge_add_core: PASSED **");
    end else begin
      $display("** sparse_triplet_merge_add_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/stma_pkg.sv
rtl/stma_if.sv
rtl/stma_ram.sv
rtl/sparse_triplet_merge_add_core.sv
tb/tb_sparse_triplet_merge_add_core.sv
